FILE: sv/esc_pkg.sv
package esc_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(WORD_W);

	localparam logic [1:0] MODE_TEMP  = 2'd0;
	localparam logic [1:0] MODE_PRESS = 2'd1;
	localparam logic [1:0] MODE_HUM   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [2:0] REG_TEMP    = 3'd0;
	localparam logic [2:0] REG_PRESS_A = 3'd1;
	localparam logic [2:0] REG_PRESS_B = 3'd2;
	localparam logic [2:0] REG_PRESS_C = 3'd3;
	localparam logic [2:0] REG_HUM     = 3'd4;

	localparam logic [31:0] K_64000     = 32'd64000;
	localparam logic [31:0] K_76800     = 32'd76800;
	localparam logic [31:0] K_HUM_MAX   = 32'd419430400;
	localparam logic [31:0] K_3125      = 32'd3125;
	localparam logic [31:0] K_1048576   = 32'd1048576;
	localparam logic [31:0] K_2097152   = 32'd2097152;
	localparam logic [31:0] K_32768     = 32'd32768;
	localparam logic [31:0] K_16384     = 32'd16384;
	localparam logic [31:0] K_8192      = 32'd8192;
	localparam logic [31:0] K_128       = 32'd128;

	// unit request from the sequencer
	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} unit_req_t;

endpackage

FILE: sv/environmental_sensor_compensation.sv
// Integer compensation of temperature, pressure and humidity readings. One beat in,
// one beat out; the block takes a new beat once the previous one has finished its
// sequence. All products and the pressure division run on one bit-serial multiplier
// and one bit-serial divider; the sequencer issues each operation and writes back
// its result. A pressure beat ends early when the divisor is zero, and a mode three
// beat runs no operation. A temperature beat updates the stored fine temperature
// used by later pressure and humidity beats.
module environmental_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // raw_reading[19:0], zero pad
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // value[32:0], divide_by_zero, zero pad
	output logic [1:0]  m_tuser,   // kind
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		asr = 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] x);
		sx16 = {{16{x[15]}}, x};
	endfunction

	logic [47:0] temp_q;
	logic [63:0] pra_q, prb_q, hum_q;
	logic [15:0] prc_q;

	logic [1:0]  st_q;
	logic [3:0]  pc_q;
	logic        wait_q;
	logic [1:0]  mode_q;
	logic [19:0] raw_q;
	logic [31:0] ft_q, v1_q, v2_q, q_q, x_q, p_q;
	logic [32:0] res_q;
	logic        dz_q;

	logic        out_v_q;
	logic [32:0] out_val_q;
	logic        out_dz_q;
	logic [1:0]  out_kind_q;

	esc_pkg::unit_req_t mul_req, div_req;
	logic        mul_done, div_done, unit_done, use_div;
	logic [31:0] mul_r, div_r, r;
	logic [31:0] op_a, op_b;

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic [31:0] adc, adc16, pv1, hx;
	logic [31:0] p5_v1, hum_y, t_out, p_out;
	logic [3:0]  last_pc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			pra_q  <= '0;
			prb_q  <= '0;
			prc_q  <= '0;
			hum_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esc_pkg::REG_TEMP:    temp_q <= cfg_data[47:0];
				esc_pkg::REG_PRESS_A: pra_q  <= cfg_data;
				esc_pkg::REG_PRESS_B: prb_q  <= cfg_data;
				esc_pkg::REG_PRESS_C: prc_q  <= cfg_data[15:0];
				esc_pkg::REG_HUM:     hum_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign t1 = {16'd0, temp_q[15:0]};
	assign t2 = sx16(temp_q[31:16]);
	assign t3 = sx16(temp_q[47:32]);
	assign p1 = {16'd0, pra_q[15:0]};
	assign p2 = sx16(pra_q[31:16]);
	assign p3 = sx16(pra_q[47:32]);
	assign p4 = sx16(pra_q[63:48]);
	assign p5 = sx16(prb_q[15:0]);
	assign p6 = sx16(prb_q[31:16]);
	assign p7 = sx16(prb_q[47:32]);
	assign p8 = sx16(prb_q[63:48]);
	assign p9 = sx16(prc_q);
	assign h1 = {24'd0, hum_q[7:0]};
	assign h2 = sx16(hum_q[23:8]);
	assign h3 = {24'd0, hum_q[31:24]};
	assign h4 = {{20{hum_q[43]}}, hum_q[43:32]};
	assign h5 = {{20{hum_q[55]}}, hum_q[55:44]};
	assign h6 = {{24{hum_q[63]}}, hum_q[63:56]};

	assign adc   = {12'd0, raw_q};
	assign adc16 = {16'd0, raw_q[15:0]};
	assign pv1   = asr(ft_q, 1) - esc_pkg::K_64000;
	assign hx    = ft_q - esc_pkg::K_76800;

	// operand selection per sequence step
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		use_div = 1'b0;
		case (mode_q)
			esc_pkg::MODE_TEMP: begin
				case (pc_q)
					4'd0: begin op_a = (adc >> 3) - (t1 << 1); op_b = t2; end
					4'd1: begin op_a = (adc >> 4) - t1; op_b = (adc >> 4) - t1; end
					4'd2: begin op_a = asr(q_q, 12); op_b = t3; end
					default: begin op_a = ft_q; op_b = 32'd5; end
				endcase
			end
			esc_pkg::MODE_PRESS: begin
				case (pc_q)
					4'd0: begin op_a = asr(pv1, 2); op_b = asr(pv1, 2); end
					4'd1: begin op_a = asr(q_q, 11); op_b = p6; end
					4'd2: begin op_a = v1_q; op_b = p5; end
					4'd3: begin op_a = p3; op_b = asr(q_q, 13); end
					4'd4: begin op_a = p2; op_b = v1_q; end
					4'd5: begin op_a = esc_pkg::K_32768 + v1_q; op_b = p1; end
					4'd6: begin
						op_a = (esc_pkg::K_1048576 - adc) - asr(v2_q, 12);
						op_b = esc_pkg::K_3125;
					end
					4'd7: begin
						use_div = 1'b1;
						op_a    = p_q[31] ? p_q : (p_q << 1);
						op_b    = v1_q;
					end
					4'd8: begin op_a = p_q >> 3; op_b = p_q >> 3; end
					4'd9: begin op_a = p9; op_b = x_q; end
					default: begin op_a = p_q >> 2; op_b = p8; end
				endcase
			end
			default: begin
				case (pc_q)
					4'd0: begin op_a = h5; op_b = hx; end
					4'd1: begin op_a = hx; op_b = h6; end
					4'd2: begin op_a = hx; op_b = h3; end
					4'd3: begin op_a = v2_q; op_b = q_q; end
					4'd4: begin op_a = v2_q; op_b = h2; end
					4'd5: begin op_a = v1_q; op_b = v2_q; end
					4'd6: begin op_a = asr(p_q, 15); op_b = asr(p_q, 15); end
					default: begin op_a = q_q; op_b = h1; end
				endcase
			end
		endcase
	end

	assign mul_req.start = (st_q == ST_RUN) && !wait_q && !use_div;
	assign mul_req.a     = op_a;
	assign mul_req.b     = op_b;
	assign div_req.start = (st_q == ST_RUN) && !wait_q && use_div;
	assign div_req.a     = op_a;
	assign div_req.b     = op_b;

	esc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .done(mul_done), .result(mul_r));
	esc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done), .result(div_r));

	assign unit_done = mul_done | div_done;
	assign r         = div_done ? div_r : mul_r;

	assign p5_v1 = asr(r, 15);
	assign hum_y = p_q - asr(r, 4);
	assign t_out = asr(r + esc_pkg::K_128, 8);
	assign p_out = p_q + asr(v1_q + asr(r, 13) + p7, 4);

	always_comb begin
		case (mode_q)
			esc_pkg::MODE_TEMP:  last_pc = 4'd3;
			esc_pkg::MODE_PRESS: last_pc = 4'd10;
			default:             last_pc = 4'd7;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			pc_q   <= '0;
			wait_q <= 1'b0;
			ft_q   <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pc_q   <= '0;
						wait_q <= 1'b0;
						st_q   <= (s_tuser == esc_pkg::MODE_NONE) ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (unit_done) begin
						wait_q <= 1'b0;
						pc_q   <= pc_q + 1'b1;
						if (mode_q == esc_pkg::MODE_TEMP && pc_q == 4'd2)
							ft_q <= v1_q + asr(r, 14);
						if (pc_q == last_pc
							|| (mode_q == esc_pkg::MODE_PRESS && pc_q == 4'd5 && p5_v1 == '0))
							st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_v_q || m_tready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and write-back of each step
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid) begin
			mode_q <= s_tuser;
			raw_q  <= s_tdata[19:0];
			res_q  <= '0;
			dz_q   <= 1'b0;
		end else if (st_q == ST_RUN && wait_q && unit_done) begin
			case (mode_q)
				esc_pkg::MODE_TEMP: begin
					case (pc_q)
						4'd0: v1_q <= asr(r, 11);
						4'd1: q_q <= r;
						4'd2: ;
						default: res_q <= {t_out[31], t_out};
					endcase
				end
				esc_pkg::MODE_PRESS: begin
					case (pc_q)
						4'd0: begin q_q <= r; v1_q <= pv1; end
						4'd1: v2_q <= r;
						4'd2: v2_q <= asr(v2_q + (r << 1), 2) + (p4 << 16);
						4'd3: x_q <= asr(r, 3);
						4'd4: v1_q <= asr(x_q + asr(r, 1), 18);
						4'd5: begin
							v1_q <= p5_v1;
							if (p5_v1 == '0) begin
								res_q <= '0;
								dz_q  <= 1'b1;
							end
						end
						4'd6: p_q <= r;
						4'd7: p_q <= p_q[31] ? (r << 1) : r;
						4'd8: x_q <= r >> 13;
						4'd9: v1_q <= asr(r, 12);
						default: res_q <= {1'b0, p_out};
					endcase
				end
				default: begin
					case (pc_q)
						4'd0: v1_q <= asr((adc16 << 14) - (h4 << 20) - r + esc_pkg::K_16384, 15);
						4'd1: v2_q <= asr(r, 10);
						4'd2: q_q <= asr(r, 11) + esc_pkg::K_32768;
						4'd3: v2_q <= asr(r, 10) + esc_pkg::K_2097152;
						4'd4: v2_q <= asr(r + esc_pkg::K_8192, 14);
						4'd5: p_q <= r;
						4'd6: q_q <= asr(r, 7);
						default: begin
							if (hum_y[31])
								res_q <= '0;
							else if (hum_y > esc_pkg::K_HUM_MAX)
								res_q <= {13'd0, esc_pkg::K_HUM_MAX[31:12]};
							else
								res_q <= {13'd0, hum_y[31:12]};
						end
					endcase
				end
			endcase
		end
	end

	// output register parts the result from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (st_q == ST_FIN && (!out_v_q || m_tready))
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && (!out_v_q || m_tready)) begin
			out_val_q  <= res_q;
			out_dz_q   <= dz_q;
			out_kind_q <= mode_q;
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_dz_q, out_val_q};
	assign m_tuser  = out_kind_q;
endmodule

FILE: sv/esc_mul.sv
module esc_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  esc_pkg::unit_req_t                  req,
	output logic                                done,
	output logic [esc_pkg::WORD_W-1:0]          result
);
	logic [esc_pkg::WORD_W-1:0] a_q, b_q, acc_q;
	logic [esc_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q, done_q;

	// one multiplier bit per cycle, low word kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == esc_pkg::CNT_W'(esc_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[esc_pkg::WORD_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[esc_pkg::WORD_W-1:1]};
		end
	end

	assign done   = done_q;
	assign result = acc_q;
endmodule

FILE: sv/esc_div.sv
module esc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  esc_pkg::unit_req_t                  req,
	output logic                                done,
	output logic [esc_pkg::WORD_W-1:0]          result
);
	logic [esc_pkg::WORD_W-1:0] quo_q, rem_q, den_q;
	logic [esc_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q, done_q;
	logic [esc_pkg::WORD_W:0]   trial;
	logic                       fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[esc_pkg::WORD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == esc_pkg::CNT_W'(esc_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.a;
			den_q <= req.b;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= esc_pkg::WORD_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[esc_pkg::WORD_W-1:0];
			quo_q <= {quo_q[esc_pkg::WORD_W-2:0], fits};
		end
	end

	assign done   = done_q;
	assign result = quo_q;
endmodule

FILE: sv/esc_checker.sv
module esc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a beat is in work");

	a_dz_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tuser == esc_pkg::MODE_PRESS && m_tdata[32:0] == '0)
		else $error("divide flag on a non-pressure or nonzero result");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == esc_pkg::MODE_NONE |-> m_tdata[33:0] == '0)
		else $error("mode three result not zero");
endmodule

bind environmental_sensor_compensation esc_checker u_esc_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: tb/environmental_sensor_compensation_tb.sv
`timescale 1ns / 100ps

module environmental_sensor_compensation_tb;

	typedef struct {
		logic [1:0]  mode;
		logic [19:0] raw;
	} reading_t;

	typedef struct {
		logic [1:0]  kind;
		logic [32:0] value;
		logic        dz;
	} comp_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	reading_t     pending_readings[$];
	comp_result_t expected_results[$];
	int           error_count = 0;
	bit           idle_enable;
	bit           hold_request;
	bit           hold_taken = 1'b0;
	int           hold_cycles = 0;

	// local copy of trims and fine temperature
	logic [47:0] tt;
	logic [63:0] pa, pb, hm;
	logic [15:0] pc;
	logic [31:0] fine_t = '0;

	environmental_sensor_compensation u_top (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic logic [31:0] sx(logic [63:0] v, int w);
		logic [31:0] m;
		logic [31:0] x;
		m = (w == 32) ? 32'hFFFFFFFF : ((32'd1 << w) - 1);
		x = v[31:0] & m;
		if (x[w-1])
			x = x | ~m;
		return x;
	endfunction

	function automatic logic [31:0] sra(logic [31:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] temperature_of(logic [31:0] adc);
		logic [31:0] t1, t2, t3, a, v1, d, v2;
		t1 = {16'd0, tt[15:0]};
		t2 = sx(tt >> 16, 16);
		t3 = sx(tt >> 32, 16);
		a = (sra(adc, 3) - (t1 << 1)) * t2;
		v1 = sra(a, 11);
		d = sra(adc, 4) - t1;
		v2 = sra(sra(d * d, 12) * t3, 14);
		fine_t = v1 + v2;
		return sra(fine_t * 32'd5 + esc_pkg::K_128, 8);
	endfunction

	function automatic logic [31:0] pressure_of(logic [31:0] adc, output logic dz);
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, q, p;
		p1 = {16'd0, pa[15:0]};
		p2 = sx(pa >> 16, 16);
		p3 = sx(pa >> 32, 16);
		p4 = sx(pa >> 48, 16);
		p5 = sx(pb, 16);
		p6 = sx(pb >> 16, 16);
		p7 = sx(pb >> 32, 16);
		p8 = sx(pb >> 48, 16);
		p9 = sx({48'd0, pc}, 16);
		dz = 1'b0;
		v1 = sra(fine_t, 1) - esc_pkg::K_64000;
		q = sra(v1, 2) * sra(v1, 2);
		v2 = sra(q, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = sra(v2, 2) + (p4 << 16);
		v1 = sra(sra(p3 * sra(q, 13), 3) + sra(p2 * v1, 1), 18);
		v1 = sra((esc_pkg::K_32768 + v1) * p1, 15);
		if (v1 == '0) begin
			dz = 1'b1;
			return '0;
		end
		p = ((esc_pkg::K_1048576 - adc) - sra(v2, 12)) * esc_pkg::K_3125;
		if (!p[31])
			p = (p << 1) / v1;
		else
			p = (p / v1) * 32'd2;
		v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
		v2 = sra((p >> 2) * p8, 13);
		return p + sra(v1 + v2 + p7, 4);
	endfunction

	function automatic logic [31:0] humidity_of(logic [31:0] adc);
		logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, y;
		h1 = {24'd0, hm[7:0]};
		h2 = sx(hm >> 8, 16);
		h3 = {24'd0, hm[31:24]};
		h4 = sx(hm >> 32, 12);
		h5 = sx(hm >> 44, 12);
		h6 = sx(hm >> 56, 8);
		x = fine_t - esc_pkg::K_76800;
		a = sra((adc << 14) - (h4 << 20) - h5 * x + esc_pkg::K_16384, 15);
		b = sra(x * h6, 10);
		b = sra(b * (sra(x * h3, 11) + esc_pkg::K_32768), 10) + esc_pkg::K_2097152;
		b = sra(b * h2 + esc_pkg::K_8192, 14);
		y = a * b;
		y = y - sra(sra(sra(y, 15) * sra(y, 15), 7) * h1, 4);
		if ($signed(y) < 0)
			y = '0;
		else if ($signed(y) > $signed(esc_pkg::K_HUM_MAX))
			y = esc_pkg::K_HUM_MAX;
		return y >> 12;
	endfunction

	function automatic comp_result_t compensate(reading_t r);
		comp_result_t c;
		logic [31:0] t;
		c.kind = r.mode;
		c.value = '0;
		c.dz = 1'b0;
		case (r.mode)
			esc_pkg::MODE_TEMP: begin
				t = temperature_of({12'd0, r.raw});
				c.value = {t[31], t};
			end
			esc_pkg::MODE_PRESS: c.value = {1'b0, pressure_of({12'd0, r.raw}, c.dz)};
			esc_pkg::MODE_HUM: c.value = {1'b0, humidity_of({16'd0, r.raw[15:0]})};
			default: c.value = '0;
		endcase
		return c;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			expected_results.push_back(compensate('{s_tuser, s_tdata[19:0]}));
		if (!s_tvalid || s_tready) begin
			if (pending_readings.size() > 0 && (!idle_enable || $urandom_range(99) >= 25)) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_readings[0].mode;
				s_tdata <= {4'd0, pending_readings[0].raw};
				void'(pending_readings.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		comp_result_t e;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				error_count++;
			end else begin
				e = expected_results.pop_front();
				if (m_tuser !== e.kind) begin
					$error("kind expected %0d actual %0d", e.kind, m_tuser);
					error_count++;
				end
				if (m_tdata[32:0] !== e.value) begin
					$error("value expected %h actual %h", e.value, m_tdata[32:0]);
					error_count++;
				end
				if (m_tdata[33] !== e.dz) begin
					$error("divide_by_zero expected %0d actual %0d", e.dz, m_tdata[33]);
					error_count++;
				end
			end
		end
		if (hold_request && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 3000;
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_enable || $urandom_range(99) >= 25;
		end
	end

	task automatic write_trim(logic [2:0] idx, logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			esc_pkg::REG_TEMP: tt = v[47:0];
			esc_pkg::REG_PRESS_A: pa = v;
			esc_pkg::REG_PRESS_B: pb = v;
			esc_pkg::REG_PRESS_C: pc = v[15:0];
			esc_pkg::REG_HUM: hm = v;
			default: ;
		endcase
	endtask

	task automatic queue_reading(logic [1:0] m, logic [19:0] r);
		pending_readings.push_back('{m, r});
	endtask

	// sampled on the falling edge so that the edge's updates have settled
	task automatic drain();
		@(negedge clk);
		while (pending_readings.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(negedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random mix of modes, mode three now and then
	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2: queue_reading(esc_pkg::MODE_TEMP, 20'($urandom()));
				3, 4, 5: queue_reading(esc_pkg::MODE_PRESS, 20'($urandom()));
				6, 7, 8: queue_reading(esc_pkg::MODE_HUM, 20'($urandom()));
				default: queue_reading(esc_pkg::MODE_NONE, 20'($urandom()));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = esc_pkg::MODE_TEMP;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_enable = 1'b0;
		hold_request = 1'b0;
		tt = '0; pa = '0; pb = '0; pc = '0; hm = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// all-zero trims: pressure divisor is zero
		queue_reading(esc_pkg::MODE_PRESS, 20'd0);
		queue_reading(esc_pkg::MODE_HUM, 20'hFFFFF);
		queue_reading(esc_pkg::MODE_TEMP, 20'hFFFFF);
		queue_reading(esc_pkg::MODE_NONE, 20'h12345);
		drain();
		// typical datasheet-like trims
		write_trim(esc_pkg::REG_TEMP, 64'h0000_0032_6A0C_6F06);
		write_trim(esc_pkg::REG_PRESS_A, {16'h0BD0, 16'hD0D0, 16'hD4E4, 16'h8E7A});
		write_trim(esc_pkg::REG_PRESS_B, {16'h1770, 16'hFFF9, 16'hFFF9, 16'h0010});
		write_trim(esc_pkg::REG_PRESS_C, 64'h0000_0000_0000_FFFF);
		write_trim(esc_pkg::REG_HUM, {8'h1E, 12'h032, 12'h145, 8'h00, 16'h0168, 8'h4B});
		write_trim(3'd7, rand64());
		queue_reading(esc_pkg::MODE_TEMP, 20'h7E000);
		queue_reading(esc_pkg::MODE_PRESS, 20'h50000);
		queue_reading(esc_pkg::MODE_HUM, 20'hF6800);
		queue_reading(esc_pkg::MODE_HUM, 20'h00000);
		queue_reading(esc_pkg::MODE_HUM, 20'h0FFFF);
		queue_reading(esc_pkg::MODE_PRESS, 20'hFFFFF);
		queue_reading(esc_pkg::MODE_PRESS, 20'h00000);
		queue_reading(esc_pkg::MODE_TEMP, 20'h00000);
		queue_reading(esc_pkg::MODE_PRESS, 20'h80000);
		queue_reading(esc_pkg::MODE_TEMP, 20'hFFFFF);
		queue_reading(esc_pkg::MODE_HUM, 20'h8000);
		queue_reading(esc_pkg::MODE_NONE, 20'hFFFFF);
		drain();
		// long receiver hold-off while the sender keeps offering
		queue_random(20);
		hold_request = 1'b1;
		drain();
		idle_enable = 1'b1;
		queue_random(130);
		drain();
		// extremes of all registers, then random trims
		write_trim(esc_pkg::REG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
		write_trim(esc_pkg::REG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_trim(esc_pkg::REG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
		write_trim(esc_pkg::REG_PRESS_C, 64'hFFFF_FFFF_FFFF_FFFF);
		write_trim(esc_pkg::REG_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_random(60);
		drain();
		for (int k = 0; k < 4; k++) begin
			write_trim(esc_pkg::REG_TEMP, rand64());
			write_trim(esc_pkg::REG_PRESS_A, rand64());
			write_trim(esc_pkg::REG_PRESS_B, rand64());
			write_trim(esc_pkg::REG_PRESS_C, rand64());
			write_trim(esc_pkg::REG_HUM, rand64());
			if (k == 2)
				idle_enable = 1'b0;
			queue_random(55);
			drain();
			idle_enable = 1'b1;
		end
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
sv/esc_pkg.sv
sv/esc_mul.sv
sv/esc_div.sv
sv/environmental_sensor_compensation.sv
sv/esc_checker.sv
tb/environmental_sensor_compensation_tb.sv
